@@ rtl/sist_pkg.sv @@
// Package with the types, codes and sizes shared by the sorted table and its cells.
`default_nettype none
package sist_pkg;

  localparam int CAPACITY = 16;
  localparam int FILL_W   = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_SEARCH = 2'd1;
  localparam logic [1:0] FUNC_DUMP   = 2'd2;

  localparam logic [2:0] ST_INSERTED   = 3'd0;
  localparam logic [2:0] ST_REJ_FULL   = 3'd1;
  localparam logic [2:0] ST_FOUND      = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
  localparam logic [2:0] ST_DUMP_ENTRY = 3'd4;
  localparam logic [2:0] ST_DUMP_EMPTY = 3'd5;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] key;
    logic [7:0] weight;
    logic [7:0] handle;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] found_handle;
    logic [7:0] found_key;
    logic [7:0] found_weight;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] key;
    logic [7:0] weight;
    logic [7:0] handle;
  } rec_t;

  // Per-cell control from the table controller.
  typedef struct packed {
    logic wr;        // an insert is committed this cycle
    logic shift;     // the insert point lies to the left: take the left neighbor
    logic occupied;  // this cell holds a record
    logic at_tail;   // this cell is the first free one
    logic sorted;    // sorted insert mode
  } cell_ctl_t;

endpackage
`default_nettype wire

@@ rtl/sist_cell.sv @@
// One record cell of the sorted table: holds a record, compares keys, shifts right on insert.
`default_nettype none
module sist_cell (
  input  wire                 clk,
  input  sist_pkg::cell_ctl_t ctl,
  input  sist_pkg::rec_t      left_rec,
  input  sist_pkg::rec_t      new_rec,
  output sist_pkg::rec_t      rec,
  output logic                mark,
  output logic                match
);

  sist_pkg::rec_t rec_r;
  sist_pkg::rec_t rec_nxt;

  // The new record lands in the first cell whose key is greater (sorted mode only), or at the tail.
  assign mark  = (ctl.occupied && ctl.sorted && (rec_r.key > new_rec.key)) || ctl.at_tail;
  assign match = ctl.occupied && (rec_r.key == new_rec.key);
  assign rec   = rec_r;

  always_comb begin
    rec_nxt = rec_r;
    if (ctl.wr) begin
      if (ctl.shift) begin
        rec_nxt = left_rec;
      end else if (mark) begin
        rec_nxt = new_rec;
      end
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

endmodule
`default_nettype wire

@@ rtl/sorted_insert_search_table_unit.sv @@
// Top level of the sorted record table: controller, cell chain and result register.
//
// The table keeps up to sist_pkg::CAPACITY records of key, weight and handle in a row of
// cells, in list order. On an insert every cell compares its key with the new key at once,
// the first cell with a greater key (or the first free cell, and always the free cell in
// append mode) takes the new record, and every cell behind it takes its left neighbor's
// record in the same clock. On a search the first matching cell in list order is chosen
// by a priority select over the match flags. Either gives one result. A dump streams one
// result per cycle, while the output is not stalled, for each stored record, read through
// a position counter, and holds off new input transfers until the last entry has left; an
// empty dump gives one result. A full table rejects inserts and is left unchanged. Input
// transfers are also held while a finished result waits in the output register under
// stall. The keep_sorted register comes out of reset set and should be written only while
// the block is idle. Function code 3 is taken and dropped without a result.
`default_nettype none
module sorted_insert_search_table_unit (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  sist_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output sist_pkg::out_item_t  out_data,
  input  wire                  cfg_we,
  input  wire                  cfg_wdata
);

  localparam int CAP = sist_pkg::CAPACITY;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  logic                        st_r, st_nxt;
  logic [sist_pkg::FILL_W-1:0] fill_r, fill_nxt;
  logic [sist_pkg::IDX_W-1:0]  didx_r, didx_nxt;
  logic                        keep_sorted_r;
  logic                        out_valid_r, out_valid_nxt;
  sist_pkg::out_item_t         out_data_r, out_data_nxt;

  sist_pkg::cell_ctl_t ctl   [CAP];
  sist_pkg::rec_t      recs  [CAP];
  sist_pkg::rec_t      lefts [CAP];
  logic [CAP-1:0]      marks;
  logic [CAP-1:0]      match_v;
  logic [CAP-1:0]      shift_v;
  logic [CAP-1:0]      first_v;

  sist_pkg::rec_t      new_rec;
  sist_pkg::rec_t      hit_rec;
  sist_pkg::rec_t      dump_rec;
  logic                out_free;
  logic                in_acc;
  logic                full;
  logic                ins_go;
  logic                dump_last;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (st_r != ST_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;
  assign full     = (fill_r == sist_pkg::FILL_W'(CAP));
  assign ins_go   = in_acc && (in_data.func == sist_pkg::FUNC_INSERT) && !full;

  assign new_rec.key    = in_data.key;
  assign new_rec.weight = in_data.weight;
  assign new_rec.handle = in_data.handle;

  // Prefix flags: a cell shifts when any cell to its left is the insert point, and a match
  // is the first one when no cell to its left also matches.
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      shift_v[i] = |(marks & ((CAP)'(1) << i) - (CAP)'(1)) ? 1'b1 : 1'b0;
      first_v[i] = match_v[i] && !(|(match_v & (((CAP)'(1) << i) - (CAP)'(1))));
    end
  end

  // The first match is one-hot, so the selected record is a plain OR of masked records.
  always_comb begin
    hit_rec = '0;
    for (int i = 0; i < CAP; i++) begin
      if (first_v[i]) begin
        hit_rec = hit_rec | recs[i];
      end
    end
  end

  assign dump_rec  = recs[didx_r];
  assign dump_last = (sist_pkg::FILL_W'(didx_r) + sist_pkg::FILL_W'(1)) == fill_r;

  genvar g;
  generate
    for (g = 0; g < CAP; g++) begin : g_cell
      assign ctl[g].wr       = ins_go;
      assign ctl[g].shift    = shift_v[g];
      assign ctl[g].occupied = sist_pkg::FILL_W'(g) < fill_r;
      assign ctl[g].at_tail  = sist_pkg::FILL_W'(g) == fill_r;
      assign ctl[g].sorted   = keep_sorted_r;
      if (g == 0) begin : g_head
        assign lefts[g] = new_rec;
      end else begin : g_body
        assign lefts[g] = recs[g-1];
      end
      sist_cell u_cell (
        .clk      (clk),
        .ctl      (ctl[g]),
        .left_rec (lefts[g]),
        .new_rec  (new_rec),
        .rec      (recs[g]),
        .mark     (marks[g]),
        .match    (match_v[g])
      );
    end
  endgenerate

  always_comb begin
    st_nxt        = st_r;
    fill_nxt      = fill_r;
    didx_nxt      = didx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (st_r == ST_DUMP) begin
      if (out_free) begin
        out_valid_nxt             = 1'b1;
        out_data_nxt.status       = sist_pkg::ST_DUMP_ENTRY;
        out_data_nxt.found_handle = dump_rec.handle;
        out_data_nxt.found_key    = dump_rec.key;
        out_data_nxt.found_weight = dump_rec.weight;
        out_data_nxt.last         = dump_last;
        didx_nxt                  = didx_r + sist_pkg::IDX_W'(1);
        if (dump_last) begin
          st_nxt = ST_IDLE;
        end
      end
    end else if (in_acc) begin
      out_data_nxt      = '0;
      out_data_nxt.last = 1'b1;
      case (in_data.func)
        sist_pkg::FUNC_INSERT: begin
          out_valid_nxt = 1'b1;
          if (full) begin
            out_data_nxt.status = sist_pkg::ST_REJ_FULL;
          end else begin
            out_data_nxt.status = sist_pkg::ST_INSERTED;
            fill_nxt            = fill_r + sist_pkg::FILL_W'(1);
          end
        end
        sist_pkg::FUNC_SEARCH: begin
          out_valid_nxt = 1'b1;
          if (|match_v) begin
            out_data_nxt.status       = sist_pkg::ST_FOUND;
            out_data_nxt.found_handle = hit_rec.handle;
            out_data_nxt.found_key    = hit_rec.key;
            out_data_nxt.found_weight = hit_rec.weight;
          end else begin
            out_data_nxt.status = sist_pkg::ST_NOT_FOUND;
          end
        end
        sist_pkg::FUNC_DUMP: begin
          if (fill_r == '0) begin
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = sist_pkg::ST_DUMP_EMPTY;
          end else begin
            didx_nxt = '0;
            st_nxt   = ST_DUMP;
          end
        end
        default: begin
          out_data_nxt = out_data_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= ST_IDLE;
      fill_r        <= '0;
      didx_r        <= '0;
      keep_sorted_r <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      fill_r      <= fill_nxt;
      didx_r      <= didx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        keep_sorted_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

@@ tb/sorted_insert_search_table_unit_tb.sv @@
// Self-checking testbench for the sorted record table: directed rows, then random traffic.
module sorted_insert_search_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Function code 3 is accepted by the block and dropped without a result.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam int RAND_ITEMS     = 280;   // random items that do real work
  localparam int RAND_PHASES    = 3;     // one register setting per phase
  localparam int HOLD_CYCLES    = 120;   // long receiver hold-off that fills the block
  localparam int SETTLE_CYCLES  = 4;     // quiet cycles before a register write
  localparam int DRAIN_CYCLES   = 20;    // quiet cycles after the last expected result
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer before giving up
  localparam int MAX_REPORTS    = 40;

  // A directed row is either one input item or one write of keep_sorted. Where the
  // expected result is plain (an acknowledge, a rejection, a miss, an empty dump) it is
  // typed in as a status; its data fields are then zero and last is one.
  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic               mode;
    sist_pkg::in_item_t item;
    logic               given;
    logic [2:0]         status;
  } directed_row_t;

  // One entry per offered item, in offer order: a typed-in result that replaces the
  // computed one when given is set.
  typedef struct packed {
    logic                given;
    sist_pkg::out_item_t res;
  } typed_result_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  sist_pkg::in_item_t  in_data   = '0;
  logic                out_stall = 1'b0;
  logic                cfg_we    = 1'b0;
  logic                cfg_wdata = 1'b0;
  logic                in_stall;
  logic                out_valid;
  sist_pkg::out_item_t out_data;

  sorted_insert_search_table_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predicted contents of the table. The block's storage is undefined until written, but
  // only positions below the record count are ever read, here and in the block.
  sist_pkg::rec_t stored [sist_pkg::CAPACITY];
  int             stored_count = 0;
  logic           sorted_mode  = 1'b1;

  sist_pkg::out_item_t pending_results [$];
  typed_result_t       typed_results [$];

  int          error_count   = 0;
  int unsigned idle_cycles   = 0;
  int unsigned gapless_left  = 0;
  logic        hold_req      = 1'b0;

  directed_row_t directed_rows [26];

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("mismatch at %0t ns: %s", $time, msg);
    end
  endtask

  task automatic compare_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want) begin
      report_error($sformatf("%s got 0x%02h, expected 0x%02h", name, got, want));
    end
  endtask

  // Applies one accepted item to the predicted table and queues the results it causes.
  task automatic apply_item(input sist_pkg::in_item_t it);
    sist_pkg::out_item_t res;
    typed_result_t       typed;
    int                  pos;
    int                  hit;
    int                  i;
    logic                single;
    res          = '0;
    res.last     = 1'b1;
    single       = 1'b1;
    typed        = '0;
    if (typed_results.size() != 0) begin
      typed = typed_results.pop_front();
    end
    case (it.func)
      sist_pkg::FUNC_INSERT: begin
        if (stored_count >= sist_pkg::CAPACITY) begin
          res.status = sist_pkg::ST_REJ_FULL;
        end else begin
          // The new record lands just before the first stored record with a greater
          // key, so equal keys stay in arrival order. Append mode always uses the tail.
          pos = stored_count;
          if (sorted_mode) begin
            for (i = stored_count - 1; i >= 0; i--) begin
              if (stored[i].key > it.key) pos = i;
            end
          end
          for (i = stored_count; i > pos; i--) begin
            stored[i] = stored[i - 1];
          end
          stored[pos] = {it.key, it.weight, it.handle};
          stored_count++;
          res.status = sist_pkg::ST_INSERTED;
        end
      end
      sist_pkg::FUNC_SEARCH: begin
        hit = -1;
        for (i = stored_count - 1; i >= 0; i--) begin
          if (stored[i].key == it.key) hit = i;
        end
        if (hit >= 0) begin
          res.status       = sist_pkg::ST_FOUND;
          res.found_handle = stored[hit].handle;
          res.found_key    = stored[hit].key;
          res.found_weight = stored[hit].weight;
        end else begin
          res.status = sist_pkg::ST_NOT_FOUND;
        end
      end
      sist_pkg::FUNC_DUMP: begin
        if (stored_count == 0) begin
          res.status = sist_pkg::ST_DUMP_EMPTY;
        end else begin
          single = 1'b0;
          for (i = 0; i < stored_count; i++) begin
            res.status       = sist_pkg::ST_DUMP_ENTRY;
            res.found_handle = stored[i].handle;
            res.found_key    = stored[i].key;
            res.found_weight = stored[i].weight;
            res.last         = (i == stored_count - 1);
            pending_results.push_back(res);
          end
        end
      end
      default: begin
        single = 1'b0;
      end
    endcase
    if (single) begin
      pending_results.push_back(typed.given ? typed.res : res);
    end
  endtask

  task automatic check_result(input sist_pkg::out_item_t got);
    sist_pkg::out_item_t want;
    if (pending_results.size() == 0) begin
      report_error($sformatf("result with nothing pending: status %0d handle 0x%02h",
                             got.status, got.found_handle));
    end else begin
      want = pending_results.pop_front();
      compare_field("status", 8'(got.status), 8'(want.status));
      compare_field("found_handle", got.found_handle, want.found_handle);
      compare_field("found_key", got.found_key, want.found_key);
      compare_field("found_weight", got.found_weight, want.found_weight);
      compare_field("last", 8'(got.last), 8'(want.last));
    end
  endtask

  // Both monitors sample at the rising edge, before the nonblocking updates of that edge
  // land, so they see exactly what the block saw. A result can never leave in the same
  // cycle as the item that caused it, so the predictor always runs first.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_stall === 1'b0) begin
      apply_item(in_data);
    end
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      check_result(out_data);
    end
  end

  // Cycles since the last transfer on either channel, for the watchdog.
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("watchdog: no transfer for %0d cycles, %0d results still pending",
             WATCHDOG_LIMIT, pending_results.size());
    $display("TB_ERROR");
    $finish;
  end

  // Receiver: runs of stall and no stall of random length, mostly short. When the sender
  // asks for it, the stall is held for a long stretch so the block backs up into its input.
  initial begin
    int unsigned run_left;
    int unsigned r;
    logic        run_val;
    run_left = 0;
    run_val  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        run_left = 0;
      end else begin
        if (run_left == 0) begin
          r = $urandom_range(0, 99);
          if (r < 40) begin
            run_val  = 1'b0;
            run_left = $urandom_range(1, 3);
          end else if (r < 70) begin
            run_val  = 1'b1;
            run_left = $urandom_range(1, 3);
          end else if (r < 92) begin
            run_val  = 1'b0;
            run_left = $urandom_range(10, 40);
          end else begin
            run_val  = 1'b1;
            run_left = $urandom_range(8, 30);
          end
        end
        out_stall <= run_val;
        run_left--;
      end
    end
  end

  // Sender gap lengths: mostly none or short, a few long, and now and then a run of items
  // with no gap at all.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (gapless_left != 0) begin
      gapless_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) gapless_left = $urandom_range(10, 40);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random item. Over half of the searches look for a stored key, so hits are common.
  function automatic sist_pkg::in_item_t random_item();
    sist_pkg::in_item_t it;
    int unsigned        r;
    it.key    = 8'($urandom);
    it.weight = 8'($urandom);
    it.handle = 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 28) begin
      it.func = sist_pkg::FUNC_INSERT;
    end else if (r < 66) begin
      it.func = sist_pkg::FUNC_SEARCH;
      if (stored_count != 0 && r < 48) begin
        it.key = stored[$urandom_range(0, stored_count - 1)].key;
      end
    end else if (r < 90) begin
      it.func = sist_pkg::FUNC_DUMP;
    end else begin
      it.func = FUNC_UNUSED;
    end
    return it;
  endfunction

  // Offers one item and returns at the edge where it was taken, with valid still high so
  // a back-to-back item can follow without a gap.
  task automatic offer_item(input sist_pkg::in_item_t it, input typed_result_t typed);
    typed_results.push_back(typed);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic pause_sender();
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits until every expected result has been seen; write_keep_sorted then waits until an
  // ignored item could no longer be in flight before writing the register. The first wait
  // also lets the monitor pick up the transfer of the edge this task was entered on.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_keep_sorted(input logic mode);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we      <= 1'b0;
    sorted_mode = mode;
  endtask

  initial begin
    sist_pkg::in_item_t it;
    typed_result_t      typed;
    int                 phase;
    int                 taken;
    logic               mode;

    // The directed rows start on an empty table in sorted mode, cover each status code,
    // equal keys, an append after sorted inserts, a sorted insert into a list that is no
    // longer in order, an ignored function code, and fill the table to its capacity.
    directed_rows = '{
      '{ROW_ITEM, 1'b0, {sist_pkg::FUNC_DUMP,   8'h00, 8'h00, 8'h00}, 1'b1,
        sist_pkg::ST_DUMP_EMPTY},
      '{ROW_ITEM, 1'b0, {sist_pkg::FUNC_SEARCH, 8'h00, 8'hFF, 8'hFF}, 1'b1,
        sist_pkg::ST_NOT_FOUND},
      '{ROW_ITEM, 1'b0, {sist_pkg::FUNC_INSERT, 8'h80, 8'h00, 8'hFF}, 1'b1,
        sist_pkg::ST_INSERTED},
      '{ROW_ITEM, 1'b0, {sist_pkg::FUNC_INSERT, 8'hFF, 8'hFF, 8'h00}, 1'b1,
        sist_pkg::ST_INSERTED},
      '{ROW_ITEM, 1'b0, {sist_pkg::FUNC_INSERT, 8'h00, 8'h55, 8'hAA}, 1'b1,
        sist_pkg::ST_INSERTED},
      '{ROW_ITEM, 1'b0, {sist_pkg::FUNC_INSERT, 8'h80, 8'h11, 8'h22}, 1'b1,
        sist_pkg::ST_INSERTED},
      '{ROW_ITEM, 1'b0, {sist_pkg::FUNC_SEARCH, 8'h80, 8'h00, 8'h00}, 1'b0,
        sist_pkg::ST_FOUND},
      '{ROW_ITEM, 1'b0, {sist_pkg::FUNC_SEARCH, 8'h7F, 8'h00, 8'h00}, 1'b1,
        sist_pkg::ST_NOT_FOUND},
      '{ROW_CFG,  1'b0, '0, 1'b0, sist_pkg::ST_INSERTED},
      '{ROW_ITEM, 1'b0, {sist_pkg::FUNC_INSERT, 8'h01, 8'hAA, 8'h55}, 1'b1,
        sist_pkg::ST_INSERTED},
      '{ROW_ITEM, 1'b0, {FUNC_UNUSED, 8'hFF, 8'hFF, 8'hFF}, 1'b0,
        sist_pkg::ST_INSERTED},
      '{ROW_CFG,  1'b1, '0, 1'b0, sist_pkg::ST_INSERTED},
      '{ROW_ITEM, 1'b0, {sist_pkg::FUNC_INSERT, 8'h02, 8'h33, 8'h44}, 1'b1,
        sist_pkg::ST_INSERTED},
      '{ROW_ITEM, 1'b0, {sist_pkg::FUNC_DUMP,   8'h00, 8'h00, 8'h00}, 1'b0,
        sist_pkg::ST_DUMP_ENTRY},
      '{ROW_ITEM, 1'b0, {sist_pkg::FUNC_INSERT, 8'h40, 8'h01, 8'h10}, 1'b1,
        sist_pkg::ST_INSERTED},
      '{ROW_ITEM, 1'b0, {sist_pkg::FUNC_INSERT, 8'h40, 8'h02, 8'h20}, 1'b1,
        sist_pkg::ST_INSERTED},
      '{ROW_ITEM, 1'b0, {sist_pkg::FUNC_INSERT, 8'hC0, 8'h04, 8'h40}, 1'b1,
        sist_pkg::ST_INSERTED},
      '{ROW_ITEM, 1'b0, {sist_pkg::FUNC_INSERT, 8'h10, 8'h08, 8'h80}, 1'b1,
        sist_pkg::ST_INSERTED},
      '{ROW_ITEM, 1'b0, {sist_pkg::FUNC_INSERT, 8'hFE, 8'h10, 8'h01}, 1'b1,
        sist_pkg::ST_INSERTED},
      '{ROW_ITEM, 1'b0, {sist_pkg::FUNC_INSERT, 8'h01, 8'h20, 8'h02}, 1'b1,
        sist_pkg::ST_INSERTED},
      '{ROW_ITEM, 1'b0, {sist_pkg::FUNC_INSERT, 8'h80, 8'h40, 8'h04}, 1'b1,
        sist_pkg::ST_INSERTED},
      '{ROW_ITEM, 1'b0, {sist_pkg::FUNC_INSERT, 8'h7F, 8'h80, 8'h08}, 1'b1,
        sist_pkg::ST_INSERTED},
      '{ROW_ITEM, 1'b0, {sist_pkg::FUNC_INSERT, 8'h20, 8'hFE, 8'hFE}, 1'b1,
        sist_pkg::ST_INSERTED},
      '{ROW_ITEM, 1'b0, {sist_pkg::FUNC_INSERT, 8'hE0, 8'h7F, 8'hF7}, 1'b1,
        sist_pkg::ST_INSERTED},
      '{ROW_ITEM, 1'b0, {sist_pkg::FUNC_INSERT, 8'h55, 8'hAA, 8'h55}, 1'b1,
        sist_pkg::ST_REJ_FULL},
      '{ROW_ITEM, 1'b0, {sist_pkg::FUNC_DUMP,   8'h00, 8'h00, 8'h00}, 1'b0,
        sist_pkg::ST_DUMP_ENTRY}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[n]) begin
      if (directed_rows[n].kind == ROW_CFG) begin
        write_keep_sorted(directed_rows[n].mode);
      end else begin
        typed            = '0;
        typed.given      = directed_rows[n].given;
        typed.res.status = directed_rows[n].status;
        typed.res.last   = 1'b1;
        offer_item(directed_rows[n].item, typed);
        pause_sender();
      end
    end

    // With no way to remove a record the table stays full from here on, so random
    // inserts all check the rejection path while searches and dumps read a full table.
    // Each phase runs under its own register setting; the middle one also holds the
    // receiver off for a long stretch while the sender keeps offering back to back.
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      if (phase == 0) mode = 1'b0;
      else if (phase == 1) mode = 1'b1;
      else mode = 1'($urandom_range(0, 1));
      write_keep_sorted(mode);
      taken = 0;
      while (taken < RAND_ITEMS / RAND_PHASES) begin
        if (phase == 1 && taken == 40) begin
          hold_req     = 1'b1;
          gapless_left = 24;
        end
        it = random_item();
        if (it.func != FUNC_UNUSED) taken++;
        offer_item(it, '0);
        pause_sender();
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
